// ----- sv/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Holds the list capacity, derived widths, the command and status codes, the
// request and result structs, and the per-cell control struct.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 16;

  localparam int PosW   = 5;
  localparam int DataW  = 32;
  localparam int FoundW = 4;
  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int CmpW   = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_DUMP   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    mode_e                    mode;
    logic [PosW-1:0]          position;
    logic signed [DataW-1:0]  value;
    logic signed [DataW-1:0]  search_key;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  result_value;
    logic [FoundW-1:0]        found_position;
    logic                     last;
  } res_t;

  // One action per cell and cycle; all low means hold.
  typedef struct packed {
    logic take_left;
    logic take_right;
    logic load;
    logic cmp;
  } cell_ctl_t;

endpackage

// ----- sv/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell: one list slot
// Stores one entry, takes a neighbor's entry or the load bus when told, and
// registers whether its entry equals the search key.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
(
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic signed [DataW-1:0] left_i,
  input  logic signed [DataW-1:0] right_i,
  input  logic signed [DataW-1:0] load_i,
  input  logic signed [DataW-1:0] key_i,
  output logic signed [DataW-1:0] data_o,
  output logic                    match_o
);

  logic signed [DataW-1:0] data_q, data_d;
  logic                    match_q, match_d;

  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    if (ctl_i.load) begin
      data_d = load_i;
    end else if (ctl_i.take_left) begin
      data_d = left_i;
    end else if (ctl_i.take_right) begin
      data_d = right_i;
    end
    if (ctl_i.cmp) begin
      match_d = (data_q == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// ----- sv/positional_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_top: ordered list of signed words in a cell chain
// Insert, delete, search and dump commands over a list of CAPACITY entries.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_i and raise start; the request is taken on a clock edge where
//   start is high and busy is low. Results come on res_o, each valid for
//   exactly one cycle while res_strobe_o is high; res_o.last marks the final
//   result of a request. The receiver cannot stall the block.
// Timing:
//   Insert and delete update the cells from the position up in the cycle
//   they are taken; their result shows in the next cycle and busy stays low,
//   so one request per cycle. Search registers a compare in every cell, then
//   priority-encodes the match bits into the registered result while busy.
//   Dump rotates the chain one cell per cycle and emits cell 0 each time:
//   count results on consecutive cycles, busy until the last; after the
//   full turn the list is back in order. An empty dump gives one result.
// Reset:
//   Clears the count and the sequencer; cell contents are not cleared and
//   only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine_top
  import ple_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_strobe_o,
  output res_t res_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic               res_strobe_q, res_strobe_d;
  res_t               res_q, res_d;

  cell_ctl_t               cell_ctl  [CAPACITY];
  logic signed [DataW-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]     cell_match;
  logic signed [DataW-1:0] load_data;

  logic                    accept;
  logic [CmpW-1:0]         pos_x;
  logic [CmpW-1:0]         cnt_x;
  logic signed [DataW-1:0] removed;
  logic                    hit;
  logic                    dump_last;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign pos_x  = CmpW'(req_i.position);
  assign cnt_x  = CmpW'(count_q);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DataW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_final
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    ple_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .load_i  (load_data),
      .key_i   (req_i.search_key),
      .data_o  (cell_data[g]),
      .match_o (cell_match[g])
    );
  end

  // Entry being deleted; only read when the position is inside the list.
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_x == CmpW'(i)) begin
        removed = cell_data[i];
      end
    end
  end

  assign dump_last = (idx_q == count_q - CntW'(1));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    res_strobe_d = 1'b0;
    res_d        = '0;
    res_d.status = ST_OK;
    load_data    = req_i.value;
    hit          = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i] = '0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.mode)
            MODE_INSERT: begin
              res_strobe_d = 1'b1;
              res_d.last   = 1'b1;
              if (pos_x > cnt_x) begin
                res_d.status = ST_INVALID;
              end else if (count_q == CntW'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                // open a gap at the position, shift the tail up
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CmpW'(i) == pos_x) begin
                    cell_ctl[i].load = 1'b1;
                  end else if (CmpW'(i) > pos_x && CmpW'(i) <= cnt_x) begin
                    cell_ctl[i].take_left = 1'b1;
                  end
                end
                count_d = count_q + CntW'(1);
              end
            end
            MODE_DELETE: begin
              res_strobe_d = 1'b1;
              res_d.last   = 1'b1;
              if (pos_x >= cnt_x) begin
                res_d.status = ST_INVALID;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CmpW'(i) >= pos_x && (CmpW'(i) + CmpW'(1)) < cnt_x) begin
                    cell_ctl[i].take_right = 1'b1;
                  end
                end
                res_d.result_value = removed;
                count_d = count_q - CntW'(1);
              end
            end
            MODE_SEARCH: begin
              for (int i = 0; i < CAPACITY; i++) begin
                cell_ctl[i].cmp = 1'b1;
              end
              state_d = S_SRCH;
            end
            MODE_DUMP: begin
              if (count_q == '0) begin
                res_strobe_d = 1'b1;
                res_d.status = ST_EMPTY;
                res_d.last   = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_DUMP;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SRCH: begin
        res_strobe_d = 1'b1;
        res_d.last   = 1'b1;
        // walk from the top so the lowest matching index wins
        for (int i = CAPACITY - 1; i >= 0; i--) begin
          if (cell_match[i] && CmpW'(i) < cnt_x) begin
            hit                  = 1'b1;
            res_d.found_position = FoundW'(i);
          end
        end
        res_d.status = hit ? ST_OK : ST_NOT_FOUND;
        state_d      = S_IDLE;
      end
      S_DUMP: begin
        res_strobe_d       = 1'b1;
        res_d.result_value = cell_data[0];
        res_d.last         = dump_last;
        // rotate: head wraps to the tail slot
        load_data = cell_data[0];
        for (int i = 0; i < CAPACITY; i++) begin
          if ((CmpW'(i) + CmpW'(1)) < cnt_x) begin
            cell_ctl[i].take_right = 1'b1;
          end else if ((CmpW'(i) + CmpW'(1)) == cnt_x) begin
            cell_ctl[i].load = 1'b1;
          end
        end
        idx_d = idx_q + CntW'(1);
        if (dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("list count above capacity");

  a_dump_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |=> res_strobe_q)
    else $error("dump cycle produced no result");

  a_search_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.mode == MODE_SEARCH) |=> (state_q == S_SRCH) ##1 res_strobe_q)
    else $error("search did not resolve in two cycles");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_q && res_q.last) |-> state_q == S_IDLE)
    else $error("final result while still busy");

  a_dump_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP || state_q == S_SRCH) |=> $stable(count_q))
    else $error("count changed during dump or search");

endmodule
